### design/tfn_pkg.sv
// Package for the triangle face normal pipeline.
// Holds the default widths shared by the top level and its sub-blocks.
// No dependencies.
package tfn_pkg;

	localparam int COORD_WIDTH      = 24;
	localparam int NORMAL_FRAC_BITS = 14;

	// Handshake of one pipeline: valid of the incoming word and the global advance.
	typedef struct packed {
		logic vld;
		logic adv;
	} pipe_ctl_t;

endpackage

### design/tfn_cross.sv
// Edge and cross product stages of the face normal pipeline (three stages).
// Depends on tfn_pkg.
module tfn_cross #(
	parameter int CW = tfn_pkg::COORD_WIDTH,
	parameter int PW = 2 * (CW + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tfn_pkg::pipe_ctl_t       ctl,
	input  logic [8:0][CW-1:0]       pts,
	output logic                     vld_s3,
	output logic [2:0]               neg_s3,
	output logic [2:0][PW-1:0]       mag_s3
);

	localparam int EW = CW + 1;

	logic                   vld_s1, vld_s2;
	logic signed [EW-1:0]   ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [PW-1:0]   pr_s2 [6];
	logic signed [PW:0]     c    [3];

	function automatic logic signed [EW-1:0] edge_d(input logic [CW-1:0] p, input logic [CW-1:0] q);
		edge_d = $signed({p[CW-1], p}) - $signed({q[CW-1], q});
	endfunction

	always_comb begin
		c[0] = $signed({pr_s2[0][PW-1], pr_s2[0]}) - $signed({pr_s2[1][PW-1], pr_s2[1]});
		c[1] = $signed({pr_s2[2][PW-1], pr_s2[2]}) - $signed({pr_s2[3][PW-1], pr_s2[3]});
		c[2] = $signed({pr_s2[4][PW-1], pr_s2[4]}) - $signed({pr_s2[5][PW-1], pr_s2[5]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			ax_s1 <= edge_d(pts[3], pts[0]);
			ay_s1 <= edge_d(pts[4], pts[1]);
			az_s1 <= edge_d(pts[5], pts[2]);
			bx_s1 <= edge_d(pts[6], pts[0]);
			by_s1 <= edge_d(pts[7], pts[1]);
			bz_s1 <= edge_d(pts[8], pts[2]);
			pr_s2[0] <= ay_s1 * bz_s1;
			pr_s2[1] <= az_s1 * by_s1;
			pr_s2[2] <= az_s1 * bx_s1;
			pr_s2[3] <= ax_s1 * bz_s1;
			pr_s2[4] <= ax_s1 * by_s1;
			pr_s2[5] <= ay_s1 * bx_s1;
			for (int k = 0; k < 3; k++) begin
				neg_s3[k] <= c[k][PW];
				mag_s3[k] <= c[k][PW] ? PW'(-c[k]) : c[k][PW-1:0];
			end
		end
	end

endmodule

### design/tfn_sumsq.sv
// Sum of squares of the cross product magnitudes, squaring split into
// half-width partial products (three stages). Depends on tfn_pkg.
module tfn_sumsq #(
	parameter int PW = 50,
	parameter int SW = 2 * PW + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfn_pkg::pipe_ctl_t   ctl,
	input  logic [2:0][PW-1:0]   mag,
	output logic                 vld_s3,
	output logic [SW-1:0]        sum_s3
);

	localparam int HL = (PW + 1) / 2;
	localparam int HH = PW - HL;

	logic                    vld_s1, vld_s2;
	logic [2*HL-1:0]         pll_s1 [3];
	logic [HL+HH-1:0]        plh_s1 [3];
	logic [2*HH-1:0]         phh_s1 [3];
	logic [2*PW-1:0]         sq_s2  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int k = 0; k < 3; k++) begin
				pll_s1[k] <= mag[k][HL-1:0] * mag[k][HL-1:0];
				plh_s1[k] <= mag[k][HL-1:0] * mag[k][PW-1:HL];
				phh_s1[k] <= mag[k][PW-1:HL] * mag[k][PW-1:HL];
				sq_s2[k]  <= ((2*PW)'(phh_s1[k]) << (2*HL)) +
					((2*PW)'(plh_s1[k]) << (HL+1)) + (2*PW)'(pll_s1[k]);
			end
			sum_s3 <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
		end
	end

endmodule

### design/tfn_isqrt.sv
// Pipelined integer square root, one root bit per stage, rounding down.
// Side data travels unchanged beside each stage. Depends on tfn_pkg.
module tfn_isqrt #(
	parameter int SW   = 102,
	parameter int XW   = 8,
	parameter int RW   = SW / 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfn_pkg::pipe_ctl_t   ctl,
	input  logic [SW-1:0]        rad,
	input  logic [XW-1:0]        side,
	output logic                 vld_out,
	output logic [RW-1:0]        root_out,
	output logic [XW-1:0]        side_out
);

	logic              vld_s  [RW+1];
	logic [RW+1:0]     rem_s  [RW+1];
	logic [RW-1:0]     root_s [RW+1];
	logic [SW-1:0]     rad_s  [RW+1];
	logic [XW-1:0]     side_s [RW+1];

	assign vld_s[0]  = ctl.vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;
	assign side_s[0] = side;

	for (genvar g = 0; g < RW; g++) begin : g_stage
		logic [RW+1:0] t, trial;
		logic          ge;
		always_comb begin
			t     = {rem_s[g][RW-1:0], rad_s[g][SW-1:SW-2]};
			trial = {root_s[g], 2'b01};
			ge    = t >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				rem_s[g+1]  <= ge ? t - trial : t;
				root_s[g+1] <= {root_s[g][RW-2:0], ge};
				rad_s[g+1]  <= rad_s[g] << 2;
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign vld_out  = vld_s[RW];
	assign root_out = root_s[RW];
	assign side_out = side_s[RW];

endmodule

### design/tfn_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage,
// giving trunc(mag * 2^F / root) with sign applied. Depends on tfn_pkg.
module tfn_div #(
	parameter int PW = 50,
	parameter int RW = PW + 1,
	parameter int F  = tfn_pkg::NORMAL_FRAC_BITS,
	parameter int NW = F + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfn_pkg::pipe_ctl_t   ctl,
	input  logic [RW-1:0]        root,
	input  logic [2:0]           neg,
	input  logic [2:0][PW-1:0]   mag,
	output logic                 vld_out,
	output logic [2:0][NW-1:0]   normal,
	output logic                 degen
);

	localparam int DW = RW + F + 1;

	logic                  vld_s  [F+2];
	logic [DW-1:0]         rem_s  [F+2][3];
	logic [NW-2:0]         q_s    [F+2][3];
	logic [RW-1:0]         root_s [F+2];
	logic [2:0]            neg_s  [F+2];

	assign vld_s[0]  = ctl.vld;
	assign root_s[0] = root;
	assign neg_s[0]  = neg;
	for (genvar l = 0; l < 3; l++) begin : g_in
		assign rem_s[0][l] = DW'(mag[l]) << F;
		assign q_s[0][l]   = '0;
	end

	for (genvar j = 0; j <= F; j++) begin : g_stage
		localparam int K = F - j;
		logic [DW-1:0] dv;
		assign dv = DW'(root_s[j]) << K;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_s[j+1] <= vld_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				root_s[j+1] <= root_s[j];
				neg_s[j+1]  <= neg_s[j];
				for (int l = 0; l < 3; l++) begin
					if (rem_s[j][l] >= dv) begin
						rem_s[j+1][l] <= rem_s[j][l] - dv;
						q_s[j+1][l]   <= q_s[j][l] | ((NW-1)'(1) << K);
					end else begin
						rem_s[j+1][l] <= rem_s[j][l];
						q_s[j+1][l]   <= q_s[j][l];
					end
				end
			end
		end
	end

	// A zero root means a zero cross product; the quotient is then forced to zero.
	assign degen   = root_s[F+1] == '0;
	assign vld_out = vld_s[F+1];
	for (genvar l = 0; l < 3; l++) begin : g_out
		logic [NW-1:0] qe;
		assign qe        = degen ? '0 : {1'b0, q_s[F+1][l]};
		assign normal[l] = neg_s[F+1][l] ? NW'(-qe) : qe;
	end

endmodule

### design/triangle_face_normal.sv
// Triangle face normal: edges, cross product, sum of squares, square root, divide.
// Throughput one triangle per cycle while the output is not stalled, kept up by the
// bit-per-stage root and divider pipes.
// A stalled output holds the whole pipeline; no word is dropped or repeated.
// Reset clears the valid bits only; data registers keep whatever they hold.
module triangle_face_normal #(
	parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH,
	parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, zero fill
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// normal_x, normal_y, normal_z, zero fill
	output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
	// degenerate
	output logic [0:0] m_tuser
);

	localparam int CW  = COORD_WIDTH;
	localparam int PW  = 2 * (CW + 1);
	localparam int SW  = 2 * PW + 2;
	localparam int RW  = SW / 2;
	localparam int NW  = NORMAL_FRAC_BITS + 2;
	localparam int XW  = 3 + 3 * PW;
	localparam int OW  = ((3*NW+7)/8)*8;

	tfn_pkg::pipe_ctl_t     ctl_in, ctl_sq, ctl_rt, ctl_dv;
	logic                   adv;
	logic [8:0][CW-1:0]     pts;
	logic                   vld_c, vld_q, vld_r;
	logic [2:0]             neg_c;
	logic [2:0][PW-1:0]     mag_c, mag_q;
	logic [2:0]             neg_q, neg_r;
	logic [2:0][PW-1:0]     mag_r;
	logic [SW-1:0]          sum_q;
	logic [RW-1:0]          root_r;
	logic [XW-1:0]          side_c, side_q, side_r;
	logic [2:0][NW-1:0]     normal;
	logic                   degen;

	// The whole pipe moves together unless a finished word is waiting.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	for (genvar i = 0; i < 9; i++) begin : g_pts
		assign pts[i] = s_tdata[i*CW +: CW];
	end

	assign ctl_in = '{vld: s_tvalid, adv: adv};
	assign ctl_sq = '{vld: vld_c, adv: adv};
	assign ctl_rt = '{vld: vld_q, adv: adv};
	assign ctl_dv = '{vld: vld_r, adv: adv};

	tfn_cross #(.CW(CW), .PW(PW)) u_cross (
		.clk, .arst_n, .ctl(ctl_in), .pts,
		.vld_s3(vld_c), .neg_s3(neg_c), .mag_s3(mag_c)
	);

	// Signs and magnitudes ride along the square and root stages.
	assign side_c = {neg_c, mag_c};

	tfn_sumsq #(.PW(PW), .SW(SW)) u_sumsq (
		.clk, .arst_n, .ctl(ctl_sq), .mag(mag_c),
		.vld_s3(vld_q), .sum_s3(sum_q)
	);

	// The sum pipe is three stages; delay the side data to match.
	logic [XW-1:0] side_s1, side_s2, side_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_c;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end
	assign side_q = side_s3;
	assign {neg_q, mag_q} = side_q;

	tfn_isqrt #(.SW(SW), .XW(XW), .RW(RW)) u_isqrt (
		.clk, .arst_n, .ctl(ctl_rt), .rad(sum_q), .side({neg_q, mag_q}),
		.vld_out(vld_r), .root_out(root_r), .side_out(side_r)
	);
	assign {neg_r, mag_r} = side_r;

	tfn_div #(.PW(PW), .RW(RW), .F(NORMAL_FRAC_BITS), .NW(NW)) u_div (
		.clk, .arst_n, .ctl(ctl_dv), .root(root_r), .neg(neg_r), .mag(mag_r),
		.vld_out(m_tvalid), .normal, .degen
	);

	assign m_tdata    = OW'(normal);
	assign m_tuser[0] = degen;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> normal == '0)
		else $error("degenerate word with nonzero normal");

	a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> normal != '0)
		else $error("non-degenerate word with zero normal");

	a_idle_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

endmodule
